/* rtl/bvb_pkg.sv */
package bvb_pkg;

  // Volume limits
  localparam int MAX_COLS  = 256;
  localparam int MAX_ROWS  = 256;
  localparam int MAX_BANDS = 256;

  // Register data width, fixed by the register map
  localparam int DIM_W  = 9;
  localparam int DIMX_W = DIM_W + 1;

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int BAND_W = $clog2(MAX_BANDS);

  localparam int PLANE_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int PLANE_AW    = $clog2(PLANE_DEPTH);
  localparam int PLANE_W     = $clog2(PLANE_DEPTH + 1);
  localparam int LEAD_W      = $clog2(PLANE_DEPTH + MAX_COLS + 2);

  // Register map
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROWS  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BANDS = CFG_IDX_W'(2);

  localparam logic [DIM_W-1:0] RESET_DIM = DIM_W'(256);

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Dimension in use: zero counts as one, anything above the limit as the limit
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r,
                                               input int unsigned maxv);
    logic [DIM_W-1:0] res;
    res = r;
    if (r == '0) begin
      res = DIM_W'(1);
    end else if (32'(r) > maxv) begin
      res = DIM_W'(maxv);
    end
    return res;
  endfunction

  localparam logic [DIM_W-1:0] RESET_EFF_C = eff_dim(RESET_DIM, MAX_COLS);
  localparam logic [DIM_W-1:0] RESET_EFF_R = eff_dim(RESET_DIM, MAX_ROWS);
  localparam logic [DIM_W-1:0] RESET_EFF_B = eff_dim(RESET_DIM, MAX_BANDS);
  localparam logic [PLANE_W-1:0] RESET_PLANE =
    PLANE_W'(int'(RESET_EFF_C) * int'(RESET_EFF_R));

  typedef struct packed {
    logic req_type;
    logic voxel;
  } in_item_t;

  typedef struct packed {
    logic border;
    logic last;
  } out_item_t;

  // One item on its way from the sequencer into the history stores
  typedef struct packed {
    logic                voxel;
    logic [PLANE_AW-1:0] plane_addr;
    logic [COL_W-1:0]    col_addr;
    logic                emit;
    logic                interior;
    logic                last;
  } tag_t;

endpackage

/* rtl/binary_volume_border_6conn.sv */
// Border extraction for a binary volume, 6-connected, streamed.
// Input channel (in_valid / in_stall / in_data): one voxel per transaction in
// raster order band, row, column; req_type set marks a flush transaction that
// only supplies a tick to drain pending results after the last voxel.
// Result channel (out_valid / out_stall / out_data): one border bit per voxel,
// same order, last set on the final voxel of the volume. The result for voxel
// j is caused by the transaction one plane plus one row plus one voxel later.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): columns, rows,
// bands at indices 0..2; cfg_ready always high. A write there restarts the volume.
// One transaction per cycle while in_stall is low. The caused result goes
// through a stage register and the result queue to out_data; the stage is the
// read-modify-write of the plane and row stores, each with one read and one
// write per cycle and a bypass when consecutive transactions hit one entry.
// Reset (synchronous, rst_n low): dimensions back to 256, all counters zero,
// result queue empty. The stores are not cleared: only entries written in the
// current volume ever reach a border decision.
// A stalled receiver fills a four-entry result queue; in_stall rises only
// when the queue and the transaction in flight would leave no room.
module binary_volume_border_6conn (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bvb_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bvb_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bvb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bvb_pkg::DIM_W-1:0]     cfg_data
);
  import bvb_pkg::*;

  logic      accept;
  logic      tag_valid;
  tag_t      tag;
  logic      res_push;
  out_item_t res;
  logic      no_room;

  // stall when the queue has no room for this transaction's result
  assign in_stall = no_room;
  assign accept   = in_valid && !in_stall;

  // counters, coordinates and dimension registers
  bvb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_data   (in_data),
    .tag_valid (tag_valid),
    .tag       (tag)
  );

  // plane and row stores, 3x3 cross window, border decision
  bvb_hist u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag_valid (tag_valid),
    .tag       (tag),
    .res_push  (res_push),
    .res       (res)
  );

  // result queue decoupling the receiver
  bvb_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .no_room   (no_room)
  );

endmodule

/* rtl/bvb_ctrl.sv */
module bvb_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bvb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bvb_pkg::DIM_W-1:0]      cfg_data,
  input  logic                           accept,
  input  bvb_pkg::in_item_t              in_data,
  output logic                           tag_valid,
  output bvb_pkg::tag_t                  tag
);
  import bvb_pkg::*;

  logic [DIM_W-1:0]    eff_c_r, eff_r_r, eff_b_r;
  logic [PLANE_W-1:0]  plane_r;
  logic [COL_W-1:0]    col_ptr_r;
  logic [ROW_W-1:0]    row_ptr_r;
  logic [BAND_W-1:0]   band_r;
  logic [PLANE_AW-1:0] plane_ptr_r;
  logic                in_done_r;
  logic [LEAD_W-1:0]   lead_r;
  logic [COL_W-1:0]    out_col_r;
  logic [ROW_W-1:0]    out_row_r;
  logic [BAND_W-1:0]   out_band_r;

  logic [DIM_W-1:0]    new_c, new_r, new_b;
  logic [2*DIM_W-1:0]  prod;
  logic [PLANE_W-1:0]  plane_nxt;
  logic                idx_ok;
  logic [LEAD_W-1:0]   lead_len;
  logic                primed, enter, restart;
  logic                col_wrap, row_wrap, band_end, plane_wrap;
  logic                oc_end, or_end, ob_end, out_last, interior;

  assign cfg_ready = 1'b1;

  always_comb begin
    new_c  = eff_c_r;
    new_r  = eff_r_r;
    new_b  = eff_b_r;
    idx_ok = 1'b1;
    case (cfg_index)
      REG_COLS:  new_c = eff_dim(cfg_data, MAX_COLS);
      REG_ROWS:  new_r = eff_dim(cfg_data, MAX_ROWS);
      REG_BANDS: new_b = eff_dim(cfg_data, MAX_BANDS);
      default:   idx_ok = 1'b0;
    endcase
    prod      = {{DIM_W{1'b0}}, new_c} * {{DIM_W{1'b0}}, new_r};
    plane_nxt = PLANE_W'(prod);
  end

  always_comb begin
    lead_len   = LEAD_W'(plane_r) + LEAD_W'(eff_c_r) + 1'b1;
    primed     = (lead_r == lead_len);
    enter      = accept && !(in_data.req_type && !in_done_r);
    col_wrap   = (DIM_W'(col_ptr_r) == eff_c_r - 1'b1);
    row_wrap   = (DIM_W'(row_ptr_r) == eff_r_r - 1'b1);
    band_end   = (DIM_W'(band_r) == eff_b_r - 1'b1);
    plane_wrap = (PLANE_W'(plane_ptr_r) == plane_r - 1'b1);
    oc_end     = (DIM_W'(out_col_r) == eff_c_r - 1'b1);
    or_end     = (DIM_W'(out_row_r) == eff_r_r - 1'b1);
    ob_end     = (DIM_W'(out_band_r) == eff_b_r - 1'b1);
    out_last   = oc_end && or_end && ob_end;
    // away from every outer face
    interior   = (out_col_r != '0) &&
                 (DIMX_W'(out_col_r) + DIMX_W'(2) <= DIMX_W'(eff_c_r)) &&
                 (out_row_r != '0) &&
                 (DIMX_W'(out_row_r) + DIMX_W'(2) <= DIMX_W'(eff_r_r)) &&
                 (out_band_r != '0) &&
                 (DIMX_W'(out_band_r) + DIMX_W'(2) <= DIMX_W'(eff_b_r));
    restart    = (cfg_valid && idx_ok) || (enter && primed && out_last);

    tag_valid       = enter;
    tag.voxel       = in_data.voxel & ~in_done_r;
    tag.plane_addr  = plane_ptr_r;
    tag.col_addr    = col_ptr_r;
    tag.emit        = primed;
    tag.interior    = interior;
    tag.last        = out_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_c_r     <= RESET_EFF_C;
      eff_r_r     <= RESET_EFF_R;
      eff_b_r     <= RESET_EFF_B;
      plane_r     <= RESET_PLANE;
      col_ptr_r   <= '0;
      row_ptr_r   <= '0;
      band_r      <= '0;
      plane_ptr_r <= '0;
      in_done_r   <= 1'b0;
      lead_r      <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_band_r  <= '0;
    end else begin
      if (cfg_valid && idx_ok) begin
        eff_c_r <= new_c;
        eff_r_r <= new_r;
        eff_b_r <= new_b;
        plane_r <= plane_nxt;
      end
      if (restart) begin
        col_ptr_r   <= '0;
        row_ptr_r   <= '0;
        band_r      <= '0;
        plane_ptr_r <= '0;
        in_done_r   <= 1'b0;
        lead_r      <= '0;
        out_col_r   <= '0;
        out_row_r   <= '0;
        out_band_r  <= '0;
      end else if (enter) begin
        if (!primed) begin
          lead_r <= lead_r + 1'b1;
        end
        plane_ptr_r <= plane_wrap ? '0 : plane_ptr_r + 1'b1;
        if (col_wrap) begin
          col_ptr_r <= '0;
          row_ptr_r <= row_wrap ? '0 : row_ptr_r + 1'b1;
          if (row_wrap && !in_done_r) begin
            if (band_end) begin
              in_done_r <= 1'b1;
            end else begin
              band_r <= band_r + 1'b1;
            end
          end
        end else begin
          col_ptr_r <= col_ptr_r + 1'b1;
        end
        if (primed) begin
          if (oc_end) begin
            out_col_r <= '0;
            if (or_end) begin
              out_row_r  <= '0;
              out_band_r <= out_band_r + 1'b1;
            end else begin
              out_row_r <= out_row_r + 1'b1;
            end
          end else begin
            out_col_r <= out_col_r + 1'b1;
          end
        end
      end
    end
  end

endmodule

/* rtl/bvb_hist.sv */
module bvb_hist (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               tag_valid,
  input  bvb_pkg::tag_t      tag,
  output logic               res_push,
  output bvb_pkg::out_item_t res
);
  import bvb_pkg::*;

  // window record: centre column plus the row above and below
  typedef struct packed {
    logic below;
    logic front;
    logic centre;
    logic back;
    logic above;
  } rec_t;

  // plane store: {one plane back, two planes back} per in-plane position
  logic [1:0] plane_mem [PLANE_DEPTH];
  // row store: {triple one row back, centre bit two rows back} per column
  logic [3:0] row_mem [MAX_COLS];

  logic       s1_valid_r;
  tag_t       s1_r;
  logic [1:0] plane_rd_r;
  logic [3:0] row_rd_r;
  logic       fwd_plane_r, fwd_row_r;
  logic [1:0] fwd_plane_data_r;
  logic [3:0] fwd_row_data_r;
  rec_t       rec1_r, rec2_r;

  logic [1:0] plane_rd;
  logic [3:0] row_rd;
  logic [2:0] trip;
  logic [1:0] plane_wr;
  logic [3:0] row_wr;
  rec_t       rec;

  always_comb begin
    plane_rd     = fwd_plane_r ? fwd_plane_data_r : plane_rd_r;
    row_rd       = fwd_row_r ? fwd_row_data_r : row_rd_r;
    trip         = {s1_r.voxel, plane_rd};
    plane_wr     = {s1_r.voxel, plane_rd[1]};
    row_wr       = {trip, row_rd[2]};
    rec.below    = trip[1];
    rec.front    = row_rd[3];
    rec.centre   = row_rd[2];
    rec.back     = row_rd[1];
    rec.above    = row_rd[0];
    res_push     = s1_valid_r && s1_r.emit;
    res.border   = s1_r.interior & rec1_r.centre &
                   ~(rec1_r.front & rec1_r.back & rec1_r.below & rec1_r.above &
                     rec.centre & rec2_r.centre);
    res.last     = s1_r.last;
  end

  always_ff @(posedge clk) begin
    if (tag_valid) begin
      plane_rd_r <= plane_mem[tag.plane_addr];
      row_rd_r   <= row_mem[tag.col_addr];
    end
    if (s1_valid_r) begin
      plane_mem[s1_r.plane_addr] <= plane_wr;
      row_mem[s1_r.col_addr]     <= row_wr;
    end
  end

  // write lands on the same edge as the next read: bypass
  always_ff @(posedge clk) begin
    if (tag_valid) begin
      s1_r             <= tag;
      fwd_plane_r      <= s1_valid_r && (tag.plane_addr == s1_r.plane_addr);
      fwd_row_r        <= s1_valid_r && (tag.col_addr == s1_r.col_addr);
      fwd_plane_data_r <= plane_wr;
      fwd_row_data_r   <= row_wr;
    end
    if (s1_valid_r) begin
      rec1_r <= rec;
      rec2_r <= rec1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= tag_valid;
    end
  end

endmodule

/* rtl/bvb_fifo.sv */
module bvb_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bvb_pkg::out_item_t push_data,
  input  logic               out_stall,
  output logic               out_valid,
  output bvb_pkg::out_item_t out_data,
  output logic               no_room
);
  import bvb_pkg::*;

  out_item_t          slot_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] count_r;
  logic               pop;

  assign out_valid = (count_r != '0);
  assign out_data  = slot_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // room kept for the entry already in flight
  assign no_room   = (count_r == FIFO_CW'(FIFO_DEPTH)) ||
                     (push && (count_r == FIFO_CW'(FIFO_DEPTH - 1)));

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + FIFO_CW'(push) - FIFO_CW'(pop);
    end
  end

endmodule

/* rtl/bvb_checker.sv */
module bvb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input bvb_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without an accepted transaction");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result queue");

endmodule

bind binary_volume_border_6conn bvb_checker u_bvb_checker (.*);

/* test/binary_volume_border_6conn_test.sv */
`timescale 1ns / 100ps

// Stream-level check of the 6-connected border extractor. Voxel and flush
// transactions come from a feed queue. Each accepted transaction goes through
// a local border predictor, which holds its own copy of the geometry and of the
// voxels of the current volume. Returned results are compared in order against
// the predictions.
module binary_volume_border_6conn_test;
  import bvb_pkg::*;

  localparam logic REQ_VOXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;
  // the one index past the register map: writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_HOLD      = 48;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 8;
  localparam int SMALL_BUDGET   = 300;
  localparam int ITEM_BUDGET    = 1350;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_COLS;
  logic [DIM_W-1:0]      cfg_data  = '0;

  binary_volume_border_6conn dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: register mirror plus the voxels of the volume in progress
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] dim_cols  = RESET_DIM;
  logic [DIM_W-1:0] dim_rows  = RESET_DIM;
  logic [DIM_W-1:0] dim_bands = RESET_DIM;
  int unsigned      vol_taken = 0;     // transactions counted in this volume
  bit               vol_voxels[$];     // voxel values of this volume, raster order
  out_item_t        border_due[$];     // predicted results not yet seen

  in_item_t         voxel_feed[$];     // transactions waiting for the driver
  int unsigned      items_queued    = 0;
  int unsigned      inputs_taken    = 0;
  int unsigned      results_checked = 0;
  int unsigned      border_seen     = 0;
  int unsigned      volumes_closed  = 0;
  int unsigned      cfg_writes      = 0;
  int unsigned      mismatches      = 0;
  int unsigned      feed_gap        = 0;
  int unsigned      hold_left       = 0;
  int unsigned      idle_cycles     = 0;
  bit               long_hold_done  = 1'b0;
  bit               calm            = 1'b0;  // no idling on either side

  task automatic log_mismatch(input string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  // zero means one, anything above the limit means the limit
  function automatic int unsigned dim_in_use(input logic [DIM_W-1:0] r,
                                             input int unsigned limit);
    if (r == '0) return 1;
    if (r > limit) return limit;
    return 32'(r);
  endfunction

  function automatic void restart_volume();
    vol_taken = 0;
    vol_voxels.delete();
  endfunction

  function automatic void apply_dim(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [DIM_W-1:0] value);
    case (idx)
      REG_COLS:  dim_cols = value;
      REG_ROWS:  dim_rows = value;
      REG_BANDS: dim_bands = value;
      default:   return;
    endcase
    restart_volume();
  endfunction

  // Works out the result, if any, that one accepted transaction causes.
  // The result for voxel j leaves on transaction j + plane + row + 1.
  function automatic void predict_border(input in_item_t item);
    int unsigned cols, rows, bands, plane, total, lag, pos, j, col, row, band;
    bit          hit;
    out_item_t   res;
    cols  = dim_in_use(dim_cols, MAX_COLS);
    rows  = dim_in_use(dim_rows, MAX_ROWS);
    bands = dim_in_use(dim_bands, MAX_BANDS);
    plane = cols * rows;
    total = plane * bands;
    lag   = plane + cols + 1;
    pos   = vol_taken;
    // flush while voxels are still owed: dropped without trace
    if (item.req_type == REQ_FLUSH && pos < total) return;
    // past the end any transaction is just a tick; its value is not kept
    if (pos < total) vol_voxels.push_back(item.voxel);
    vol_taken = pos + 1;
    if (pos < lag) return;
    j    = pos - lag;
    col  = j % cols;
    row  = (j / cols) % rows;
    band = j / plane;
    hit  = 1'b0;
    // outer faces never count, which also covers any dimension under 3
    if (band >= 1 && band + 2 <= bands && row >= 1 && row + 2 <= rows &&
        col >= 1 && col + 2 <= cols && vol_voxels[j]) begin
      hit = !vol_voxels[j - plane] || !vol_voxels[j + plane] ||
            !vol_voxels[j - cols]  || !vol_voxels[j + cols]  ||
            !vol_voxels[j - 1]     || !vol_voxels[j + 1];
    end
    res.border = hit;
    res.last   = (j + 1 == total);
    border_due.push_back(res);
    if (res.last) restart_volume();
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one transaction per handshake, random gaps, payload held on stall
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : voxel_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_border(in_data);
        inputs_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (feed_gap > 0) begin
          in_valid <= 1'b0;
          feed_gap--;
        end else if (voxel_feed.size() != 0 && !calm && $urandom_range(0, 7) == 0) begin
          in_valid <= 1'b0;
          feed_gap = $urandom_range(0, 2);
        end else if (voxel_feed.size() != 0) begin
          in_data  <= voxel_feed.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: checks each result against the oldest prediction, stalls at random
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (border_due.size() == 0) begin
          log_mismatch($sformatf("result %0d with nothing expected (border %b last %b)",
                                 results_checked, out_data.border, out_data.last));
        end else begin
          want = border_due.pop_front();
          if (out_data.border !== want.border)
            log_mismatch($sformatf("result %0d border %b, expected %b",
                                   results_checked, out_data.border, want.border));
          if (out_data.last !== want.last)
            log_mismatch($sformatf("result %0d last %b, expected %b",
                                   results_checked, out_data.last, want.last));
        end
        results_checked++;
        if (out_data.border === 1'b1) border_seen++;
        if (out_data.last === 1'b1) volumes_closed++;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!long_hold_done && results_checked >= 60 && voxel_feed.size() > 8) begin
        // long hold-off: result queue fills and the block must push back on its input
        out_stall <= 1'b1;
        hold_left = LONG_HOLD - 1;
        long_hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        hold_left = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Ends the run when no transaction of any kind moves for too long
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("binary_volume_border_6conn regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_item(input logic req, input logic vox);
    in_item_t it;
    it.req_type = req;
    it.voxel    = vox;
    voxel_feed.push_back(it);
    items_queued++;
  endtask

  // n_vox voxels at fg_pct percent foreground, then n_ticks drain transactions
  task automatic queue_volume(input int unsigned fg_pct, input int unsigned n_vox,
                              input int unsigned n_ticks);
    int unsigned k;
    for (k = 0; k < n_vox; k++) begin
      if ($urandom_range(0, 15) == 0) push_item(REQ_FLUSH, $urandom_range(0, 1) != 0);
      push_item(REQ_VOXEL, $urandom_range(0, 99) < fg_pct);
    end
    // a voxel transaction after the volume drains just like a flush
    for (k = 0; k < n_ticks; k++)
      push_item($urandom_range(0, 3) == 0 ? REQ_VOXEL : REQ_FLUSH,
                $urandom_range(0, 1) != 0);
    if (n_ticks != 0 && $urandom_range(0, 3) == 0) push_item(REQ_FLUSH, 1'b1);
  endtask

  // call only when idle and in sync with the rising clock
  task automatic write_dim(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_index <= idx;
    cfg_data  <= value[DIM_W-1:0];
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_dim(idx, value[DIM_W-1:0]);
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // everything sent, every prediction matched, then a settling wait for the pipe
  task automatic settle();
    while (voxel_feed.size() != 0 || in_valid || border_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_small_phase();
    int unsigned c, r, b, vols, v, fg, total, lag, n_vox;
    c = $urandom_range(3, 6);
    r = $urandom_range(3, 5);
    b = $urandom_range(3, 4);
    // now and then a thin volume: no interior at all
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 2))
        0:       c = 2;
        1:       r = 2;
        default: b = 2;
      endcase
    end
    write_dim(REG_COLS, c);
    write_dim(REG_ROWS, r);
    write_dim(REG_BANDS, b);
    total = c * r * b;
    lag   = c * r + c + 1;
    vols  = $urandom_range(1, 2);
    for (v = 0; v < vols; v++) begin
      case ($urandom_range(0, 2))
        0:       fg = 50;
        1:       fg = 85;
        default: fg = 97;
      endcase
      if (v == vols - 1 && $urandom_range(0, 3) == 0) begin
        // cut short; the next register write restarts the volume
        n_vox = $urandom_range(1, total);
        queue_volume(fg, n_vox, n_vox == total ? $urandom_range(0, lag - 1) : 0);
      end else begin
        queue_volume(fg, total, lag);
      end
    end
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry is far too big to finish: a mid-volume flush is dropped,
    // a voxel is stored, and nothing comes out.
    push_item(REQ_FLUSH, 1'b1);
    push_item(REQ_VOXEL, 1'b1);
    settle();

    // Single voxel volume, columns written as zero. Stray flush first, then a
    // voxel transaction after the end acting as a tick, then the closing result.
    write_dim(REG_COLS, 0);
    write_dim(REG_ROWS, 1);
    write_dim(REG_BANDS, 1);
    push_item(REQ_FLUSH, 1'b0);
    push_item(REQ_VOXEL, 1'b1);
    push_item(REQ_VOXEL, 1'b1);
    push_item(REQ_FLUSH, 1'b0);
    push_item(REQ_FLUSH, 1'b1);
    settle();

    // Two-voxel volume with a write to the spare index half way: must not restart
    write_dim(REG_BANDS, 2);
    push_item(REQ_VOXEL, 1'b1);
    settle();
    write_dim(REG_SPARE, 511);
    push_item(REQ_VOXEL, 1'b0);
    push_item(REQ_FLUSH, 1'b0);
    push_item(REQ_VOXEL, 1'b1);
    push_item(REQ_FLUSH, 1'b1);
    settle();

    while (items_queued < SMALL_BUDGET) run_small_phase();

    // deepest stack of bands, one voxel per plane, run to the end
    write_dim(REG_COLS, 1);
    write_dim(REG_ROWS, 1);
    write_dim(REG_BANDS, 256);
    queue_volume(85, 256, 3);
    settle();

    // widest row (clamped from 511), rows written as zero: longest lag with results
    write_dim(REG_COLS, 511);
    write_dim(REG_ROWS, 0);
    write_dim(REG_BANDS, 1);
    queue_volume(85, 256, 261);
    settle();

    // tallest band (clamped from 300), left part way
    write_dim(REG_COLS, 1);
    write_dim(REG_ROWS, 300);
    write_dim(REG_BANDS, 1);
    queue_volume(50, 40, 0);
    settle();

    // closing stretch at full rate both ways
    calm = 1'b1;
    while (items_queued < ITEM_BUDGET) run_small_phase();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (border_due.size() != 0)
      log_mismatch($sformatf("%0d results never arrived", border_due.size()));
    $display("covered %0d input transactions and %0d register writes over many geometries",
             inputs_taken, cfg_writes);
    $display("checked %0d results: %0d border voxels, %0d volumes closed",
             results_checked, border_seen, volumes_closed);
    if (mismatches == 0) begin
      $display("binary_volume_border_6conn regression: pass");
    end else begin
      $display("binary_volume_border_6conn regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/bvb_pkg.sv
rtl/bvb_ctrl.sv
rtl/bvb_hist.sv
rtl/bvb_fifo.sv
rtl/binary_volume_border_6conn.sv
rtl/bvb_checker.sv
test/binary_volume_border_6conn_test.sv
